[design/tlv_frame_deframer_crc16_defines.svh]
// Assertion macros for the TLV deframer checker.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef TLV_FRAME_DEFRAMER_CRC16_DEFINES_SVH
`define TLV_FRAME_DEFRAMER_CRC16_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define TLVDF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlvdf: same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent
`define TLVDF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlvdf: next-cycle check failed");

`endif

[design/tlvdf_pkg.sv]
package tlvdf_pkg;

    localparam int BYTE_W   = 8;
    localparam int FIELD_W  = 16;
    localparam int STATUS_W = 2;

    localparam logic [FIELD_W-1:0] CRC_POLY       = 16'h1021;
    localparam logic [FIELD_W-1:0] CRC_SEED_RESET = 16'hFFFF;

    // Result item kinds
    localparam logic KIND_VALUE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Frame status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SHORT    = 2'd2;

    // Position within the frame
    typedef enum logic [2:0] {
        PH_TAG_HI = 3'd0,
        PH_TAG_LO = 3'd1,
        PH_LEN_HI = 3'd2,
        PH_LEN_LO = 3'd3,
        PH_VALUE  = 3'd4,
        PH_CRC_HI = 3'd5,
        PH_CRC_LO = 3'd6,
        PH_DROP   = 3'd7
    } phase_t;

    // Advance CRC-ITU-T by one byte, MSB first
    function automatic logic [FIELD_W-1:0] crc_byte(input logic [FIELD_W-1:0] crc,
                                                    input logic [BYTE_W-1:0]  b);
        logic [FIELD_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (c[FIELD_W-1])
                c = {c[FIELD_W-2:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[FIELD_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage

[design/tlvdf_byte_if.sv]
interface tlvdf_byte_if
    import tlvdf_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   data_byte;
    logic                end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

[design/tlvdf_item_if.sv]
interface tlvdf_item_if
    import tlvdf_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                item_kind;
    logic [BYTE_W-1:0]   value_byte;
    logic [FIELD_W-1:0]  frame_tag;
    logic [FIELD_W-1:0]  frame_length;
    logic [STATUS_W-1:0] frame_status;
    logic                last_of_frame;

    modport source (output valid, output item_kind, output value_byte, output frame_tag,
                    output frame_length, output frame_status, output last_of_frame,
                    input ready);
    modport sink   (input valid, input item_kind, input value_byte, input frame_tag,
                    input frame_length, input frame_status, input last_of_frame,
                    output ready);
endinterface

[design/tlv_frame_deframer_crc16.sv]
// TLV deframer with CRC-ITU-T check. Takes one message byte per cycle on rx
// while rx.ready is high and returns at most one word per byte on res: each
// value byte as it arrives, and one status word (ok, crc_mismatch or
// too_short) carrying the tag and length when the frame ends. The CRC is
// updated bytewise and combinationally; each result is held in a result
// register and appears in the cycle after its byte is taken. rx.ready is
// high whenever that register is empty or being drained in the same cycle.
// crc_seed (reset 0xFFFF) is loaded at the first byte of each frame.
module tlv_frame_deframer_crc16
    import tlvdf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [FIELD_W-1:0] cfg_wr_data,
    tlvdf_byte_if.sink         rx,
    tlvdf_item_if.source       res
);

    logic [FIELD_W-1:0]  crc_seed_reg;
    phase_t              phase_reg, phase_next;
    logic [FIELD_W-1:0]  tag_reg, tag_next;
    logic [FIELD_W-1:0]  length_reg, length_next;
    logic [FIELD_W-1:0]  count_reg, count_next;
    logic [FIELD_W-1:0]  crc_reg, crc_next;
    logic [BYTE_W-1:0]   crc_high_reg, crc_high_next;

    logic                res_valid_reg, res_valid_next;
    logic                res_kind_reg, res_kind_next;
    logic [BYTE_W-1:0]   res_byte_reg, res_byte_next;
    logic [FIELD_W-1:0]  res_tag_reg;
    logic [FIELD_W-1:0]  res_length_reg;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;

    logic                accept;
    logic                emit;
    logic                value_out;
    logic                frame_done;
    logic [STATUS_W-1:0] crc_status;

    assign rx.ready = !res_valid_reg || res.ready;
    assign accept   = rx.valid && rx.ready;

    // Hold the seed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crc_seed_reg <= CRC_SEED_RESET;
        else if (cfg_wr_en)
            crc_seed_reg <= cfg_wr_data;
    end

    // Decode one byte against the frame position
    always_comb
    begin
        phase_next    = phase_reg;
        tag_next      = tag_reg;
        length_next   = length_reg;
        count_next    = count_reg;
        crc_next      = crc_reg;
        crc_high_next = crc_high_reg;
        value_out     = 1'b0;
        frame_done    = 1'b0;
        crc_status    = ST_OK;

        unique case (phase_reg)
            PH_TAG_HI:
            begin
                tag_next      = {rx.data_byte, 8'h00};
                length_next   = '0;
                count_next    = '0;
                crc_high_next = '0;
                crc_next      = crc_byte(crc_seed_reg, rx.data_byte);
                phase_next    = PH_TAG_LO;
            end
            PH_TAG_LO:
            begin
                tag_next   = {tag_reg[FIELD_W-1:BYTE_W], rx.data_byte};
                crc_next   = crc_byte(crc_reg, rx.data_byte);
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                length_next = {rx.data_byte, 8'h00};
                crc_next    = crc_byte(crc_reg, rx.data_byte);
                phase_next  = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                length_next = {length_reg[FIELD_W-1:BYTE_W], rx.data_byte};
                crc_next    = crc_byte(crc_reg, rx.data_byte);
                count_next  = '0;
                phase_next  = (length_next == '0) ? PH_CRC_HI : PH_VALUE;
            end
            PH_VALUE:
            begin
                crc_next   = crc_byte(crc_reg, rx.data_byte);
                count_next = count_reg + 16'd1;
                value_out  = 1'b1;
                if (count_next == length_reg)
                    phase_next = PH_CRC_HI;
            end
            PH_CRC_HI:
            begin
                crc_high_next = rx.data_byte;
                phase_next    = PH_CRC_LO;
            end
            PH_CRC_LO:
            begin
                frame_done = 1'b1;
                crc_status = ({crc_high_reg, rx.data_byte} == crc_reg) ? ST_OK : ST_MISMATCH;
                phase_next = rx.end_of_message ? PH_TAG_HI : PH_DROP;
            end
            PH_DROP:
            begin
                if (rx.end_of_message)
                    phase_next = PH_TAG_HI;
            end
        endcase

        // Pick the result word: frame end, early end, then value byte
        emit            = 1'b0;
        res_kind_next   = KIND_VALUE;
        res_byte_next   = '0;
        res_status_next = ST_OK;
        priority if (frame_done)
        begin
            emit            = 1'b1;
            res_kind_next   = KIND_STATUS;
            res_status_next = crc_status;
        end
        else if (rx.end_of_message && phase_reg != PH_DROP)
        begin
            emit            = 1'b1;
            phase_next      = PH_TAG_HI;
            res_kind_next   = KIND_STATUS;
            res_status_next = ST_SHORT;
        end
        else if (value_out)
        begin
            emit          = 1'b1;
            res_byte_next = rx.data_byte;
        end
        else
        begin
            emit = 1'b0;
        end

        // Result register occupancy
        if (accept)
            res_valid_next = emit;
        else if (res.ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    // Advance frame state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_TAG_HI;
            tag_reg       <= '0;
            length_reg    <= '0;
            count_reg     <= '0;
            crc_reg       <= CRC_SEED_RESET;
            crc_high_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (accept)
            begin
                phase_reg    <= phase_next;
                tag_reg      <= tag_next;
                length_reg   <= length_next;
                count_reg    <= count_next;
                crc_reg      <= crc_next;
                crc_high_reg <= crc_high_next;
            end
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            res_kind_reg   <= res_kind_next;
            res_byte_reg   <= res_byte_next;
            res_tag_reg    <= tag_next;
            res_length_reg <= length_next;
            res_status_reg <= res_status_next;
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.item_kind     = res_kind_reg;
    assign res.value_byte    = res_byte_reg;
    assign res.frame_tag     = res_tag_reg;
    assign res.frame_length  = res_length_reg;
    assign res.frame_status  = res_status_reg;
    assign res.last_of_frame = res_kind_reg;

endmodule

[design/tlvdf_checker.sv]
`include "tlv_frame_deframer_crc16_defines.svh"

module tlvdf_checker
    import tlvdf_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                rx_ready,
    input logic                res_valid,
    input logic                res_ready,
    input logic                res_item_kind,
    input logic [BYTE_W-1:0]   res_value_byte,
    input logic [STATUS_W-1:0] res_frame_status,
    input logic                res_last_of_frame
);

    // Status words close the frame, value words never do
    `TLVDF_ASSERT_SAME(a_last_matches_kind, res_valid, res_last_of_frame == res_item_kind)

    // Value words carry an ok status field
    `TLVDF_ASSERT_SAME(a_value_status_zero, res_valid && res_item_kind == KIND_VALUE,
                       res_frame_status == ST_OK)

    // Status words carry a zero byte and a defined code
    `TLVDF_ASSERT_SAME(a_status_fields, res_valid && res_item_kind == KIND_STATUS,
                       res_value_byte == '0 && res_frame_status <= ST_SHORT)

    // Empty result register never blocks input
    `TLVDF_ASSERT_SAME(a_ready_when_empty, !res_valid, rx_ready)

    // A stalled result word stays offered
    `TLVDF_ASSERT_NEXT(a_res_holds, res_valid && !res_ready, res_valid)

endmodule

bind tlv_frame_deframer_crc16 tlvdf_checker u_tlvdf_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .rx_ready          (rx.ready),
    .res_valid         (res.valid),
    .res_ready         (res.ready),
    .res_item_kind     (res.item_kind),
    .res_value_byte    (res.value_byte),
    .res_frame_status  (res.frame_status),
    .res_last_of_frame (res.last_of_frame)
);
